// ===== hdl/bfr_pkg.sv =====
// Shared types, codes and size constants of the bitstream field reader.
package bfr_pkg;

    localparam int STORE_DEPTH_DEF     = 4096;
    localparam int MAX_FIELD_BYTES_DEF = 8;

    localparam int ADDR_W  = 12;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 7;
    localparam int VALUE_W = 64;
    localparam int SEEK_W  = 3;
    localparam int DLEN_W  = 13;
    localparam int POS_W   = 17;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register index decoded from paddr[2].
    localparam logic REG_DATA_LENGTH = 1'b0;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_GET  = 2'd1,
        CMD_FIND = 2'd2,
        CMD_SEEK = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_END       = 2'd1,
        ST_REJECT    = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd                 cmd;
        logic [ADDR_W-1:0]    address;
        logic [BYTE_W-1:0]    byte_value;
        logic [COUNT_W-1:0]   count_bits;
        logic [VALUE_W-1:0]   pattern;
        logic [SEEK_W-1:0]    seek_bit;
    } t_cmd_item;

    typedef struct packed {
        logic [VALUE_W-1:0]   bits_value;
        t_status              status;
        logic [DLEN_W-1:0]    byte_position;
        logic [SEEK_W-1:0]    bit_position;
    } t_result;

endpackage

// ===== hdl/bfr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bfr_ram #(
    parameter int WIDTH = bfr_pkg::BYTE_W,
    parameter int DEPTH = bfr_pkg::STORE_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold the last read word when no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/bitstream_field_reader.sv =====
// Top level: MSB-first bit reader with pattern search over a byte store.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-------------------------------
//  command  | in        | start && !busy         | i_item   (bfr_pkg::t_cmd_item)
//  result   | out       | o_done (one cycle)     | o_result (bfr_pkg::t_result)
//  config   | in/out    | psel&penable&pwrite    | paddr, pwdata, prdata
//
// Load and seek pass through S_EXEC alone from accept back to idle, as do a
// rejected or end-of-data get or find. A get reads its span of
// nb = 1..MAX_FIELD_BYTES+1 bytes through the single byte-wide read port, one per
// cycle, and then ends in S_GET_FIN. A find first loads its byte in S_FIND_LD,
// then walks one bit per cycle through a one-bit window shifter.
// Reset (i_rst_n low, synchronous) clears the cursor, data_length and the
// control state; the byte store keeps no reset and is undefined until loaded.
// The result strobe o_done lasts one cycle and cannot be stalled; busy is low
// in that cycle, so the next item may be accepted while the result is shown.
module bitstream_field_reader #(
    parameter int STORE_DEPTH     = bfr_pkg::STORE_DEPTH_DEF,
    parameter int MAX_FIELD_BYTES = bfr_pkg::MAX_FIELD_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          start,
    output logic                          busy,
    input  bfr_pkg::t_cmd_item            i_item,
    // result channel
    output logic                          o_done,
    output bfr_pkg::t_result              o_result,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bfr_pkg::PADDR_W-1:0]   paddr,
    input  logic [bfr_pkg::PDATA_W-1:0]   pwdata,
    output logic [bfr_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int POS_W    = bfr_pkg::POS_W;
    localparam int BA_W     = POS_W - 3;                 // byte index of a bit position
    localparam int AW       = $clog2(STORE_DEPTH);
    localparam int ACC_W    = 8 * MAX_FIELD_BYTES + 8;   // widest byte span of a get
    localparam int CNT_W    = $clog2(MAX_FIELD_BYTES + 2);
    localparam int MAX_BITS = 8 * MAX_FIELD_BYTES;
    localparam int VALUE_W  = bfr_pkg::VALUE_W;
    localparam int DLEN_W   = bfr_pkg::DLEN_W;
    localparam int COUNT_W  = bfr_pkg::COUNT_W;
    localparam logic [POS_W-1:0] DEPTH_L = POS_W'(STORE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_GET,
        S_GET_FIN,
        S_FIND_LD,
        S_FIND
    } t_state;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state                 r_state,     n_state;
    bfr_pkg::t_cmd_item     r_item,      n_item;
    logic [DLEN_W-1:0]      r_cur_byte,  n_cur_byte;
    logic [2:0]             r_cur_bit,   n_cur_bit;
    logic [DLEN_W-1:0]      r_dlen,      n_dlen;
    logic                   r_done,      n_done;
    bfr_pkg::t_result       r_result,    n_result;
    logic [BA_W-1:0]        r_rd_addr,   n_rd_addr;
    logic [CNT_W-1:0]       r_issue_left, n_issue_left;
    logic [CNT_W-1:0]       r_recv_left, n_recv_left;
    logic                   r_rvalid,    n_rvalid;
    logic [ACC_W-1:0]       r_acc,       n_acc;
    logic [POS_W-1:0]       r_last,      n_last;
    logic [2:0]             r_sh,        n_sh;
    logic [VALUE_W-1:0]     r_mask,      n_mask;
    logic [POS_W-1:0]       r_spos,      n_spos;
    logic [COUNT_W-1:0]     r_fill,      n_fill;
    logic [VALUE_W-1:0]     r_win,       n_win;
    logic [7:0]             r_bitbuf,    n_bitbuf;

    // ------------------------------------------------------------------
    // Byte store
    // ------------------------------------------------------------------
    logic                   ram_we;
    logic                   ram_re;
    logic [BA_W-1:0]        ram_rbyte;
    logic [7:0]             ram_rdata;

    bfr_ram #(
        .WIDTH (bfr_pkg::BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(r_item.address)),
        .i_wdata (r_item.byte_value),
        .i_re    (ram_re),
        .i_raddr (AW'(ram_rbyte)),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Position arithmetic on the held item and the cursor
    // ------------------------------------------------------------------
    logic [POS_W-1:0]       pos;
    logic [POS_W-1:0]       n17;
    logic [POS_W-1:0]       addr17;
    logic [POS_W-1:0]       dlen17;
    logic [POS_W-1:0]       dlen_eff;
    logic [POS_W-1:0]       total;
    logic                   width_bad;
    logic                   no_room;
    logic [POS_W-1:0]       end_pos;
    logic [POS_W-1:0]       last_bit;
    logic [BA_W-1:0]        span;
    logic [CNT_W-1:0]       nbytes;
    logic [VALUE_W-1:0]     mask_new;
    logic [VALUE_W-1:0]     pat_m;
    logic                   bit_in;
    logic [VALUE_W-1:0]     win_next;
    logic [COUNT_W-1:0]     fill_next;
    logic                   hit;
    logic [POS_W-1:0]       s_next;
    logic [POS_W-1:0]       match_pos;
    logic [VALUE_W-1:0]     get_value;
    logic                   cfg_we;

    assign pos      = {1'b0, r_cur_byte, r_cur_bit};
    assign n17      = POS_W'(r_item.count_bits);
    assign addr17   = POS_W'(r_item.address);
    assign dlen17   = POS_W'(r_dlen);
    // a length beyond the store acts as the store size
    assign dlen_eff = (dlen17 > DEPTH_L) ? DEPTH_L : dlen17;
    assign total    = {dlen_eff[POS_W-4:0], 3'b000};

    assign width_bad = (r_item.count_bits == '0) || (n17 > POS_W'(MAX_BITS));
    // cursor may lie past the data after data_length shrinks
    assign no_room   = (pos > total) || ((total - pos) < n17);

    assign end_pos  = pos + n17;
    assign last_bit = end_pos - POS_W'(1);
    assign span     = last_bit[POS_W-1:3] - pos[POS_W-1:3];
    assign nbytes   = CNT_W'(span) + CNT_W'(1);

    assign mask_new = (r_item.count_bits >= COUNT_W'(VALUE_W)) ? '1 :
                      ((VALUE_W'(1) << r_item.count_bits) - VALUE_W'(1));
    assign pat_m    = r_item.pattern & r_mask;

    // find: shift one stream bit per cycle into the window
    assign bit_in    = r_bitbuf[3'd7 - r_spos[2:0]];
    assign win_next  = {r_win[VALUE_W-2:0], bit_in};
    assign fill_next = (r_fill == r_item.count_bits) ? r_fill : r_fill + COUNT_W'(1);
    assign hit       = (fill_next == r_item.count_bits) && ((win_next & r_mask) == pat_m);
    assign s_next    = r_spos + POS_W'(1);
    assign match_pos = s_next - n17;

    // get: the last byte read holds the field's last bit at offset 7 - r_sh
    assign get_value = VALUE_W'(r_acc >> r_sh) & r_mask;

    assign cfg_we = psel && penable && pwrite && (paddr[2] == bfr_pkg::REG_DATA_LENGTH);

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    logic                   fin;
    bfr_pkg::t_status       fin_status;
    logic [VALUE_W-1:0]     fin_value;

    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_cur_byte   = r_cur_byte;
        n_cur_bit    = r_cur_bit;
        n_dlen       = r_dlen;
        n_done       = 1'b0;
        n_result     = r_result;
        n_rd_addr    = r_rd_addr;
        n_issue_left = r_issue_left;
        n_recv_left  = r_recv_left;
        n_rvalid     = 1'b0;
        n_acc        = r_acc;
        n_last       = r_last;
        n_sh         = r_sh;
        n_mask       = r_mask;
        n_spos       = r_spos;
        n_fill       = r_fill;
        n_win        = r_win;
        n_bitbuf     = r_bitbuf;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_rbyte    = r_rd_addr;
        fin          = 1'b0;
        fin_status   = bfr_pkg::ST_OK;
        fin_value    = '0;

        if (cfg_we) begin
            n_dlen = pwdata[DLEN_W-1:0];
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_item  = i_item;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_item.cmd) inside
                    bfr_pkg::CMD_LOAD: begin
                        fin = 1'b1;
                        if (addr17 < DEPTH_L) begin
                            ram_we = 1'b1;
                        end else begin
                            fin_status = bfr_pkg::ST_REJECT;
                        end
                    end
                    bfr_pkg::CMD_SEEK: begin
                        fin = 1'b1;
                        if ((addr17 < dlen17) && (addr17 < DEPTH_L)) begin
                            n_cur_byte = DLEN_W'(r_item.address);
                            n_cur_bit  = r_item.seek_bit;
                        end else begin
                            fin_status = bfr_pkg::ST_REJECT;
                        end
                    end
                    bfr_pkg::CMD_GET, bfr_pkg::CMD_FIND: begin
                        n_mask = mask_new;
                        if (width_bad) begin
                            fin        = 1'b1;
                            fin_status = bfr_pkg::ST_REJECT;
                        end else if (no_room) begin
                            fin        = 1'b1;
                            fin_status = bfr_pkg::ST_END;
                        end else if (r_item.cmd == bfr_pkg::CMD_GET) begin
                            n_rd_addr    = pos[POS_W-1:3];
                            n_issue_left = nbytes;
                            n_recv_left  = nbytes;
                            n_last       = end_pos;
                            n_sh         = 3'd7 - last_bit[2:0];
                            n_state      = S_GET;
                        end else begin
                            // fetch the byte under the cursor
                            ram_re    = 1'b1;
                            ram_rbyte = pos[POS_W-1:3];
                            n_spos    = pos;
                            n_fill    = '0;
                            n_state   = S_FIND_LD;
                        end
                    end
                endcase
            end
            S_GET: begin
                if (r_issue_left != '0) begin
                    ram_re       = 1'b1;
                    ram_rbyte    = r_rd_addr;
                    n_rd_addr    = r_rd_addr + BA_W'(1);
                    n_issue_left = r_issue_left - CNT_W'(1);
                    n_rvalid     = 1'b1;
                end
                if (r_rvalid) begin
                    n_acc       = {r_acc[ACC_W-9:0], ram_rdata};
                    n_recv_left = r_recv_left - CNT_W'(1);
                    if (r_recv_left == CNT_W'(1)) begin
                        n_state = S_GET_FIN;
                    end
                end
            end
            S_GET_FIN: begin
                fin        = 1'b1;
                fin_value  = get_value;
                n_cur_byte = r_last[POS_W-2:3];
                n_cur_bit  = r_last[2:0];
            end
            S_FIND_LD: begin
                // first byte arrives; prefetch the one after it
                n_bitbuf  = ram_rdata;
                ram_re    = 1'b1;
                ram_rbyte = r_spos[POS_W-1:3] + BA_W'(1);
                n_state   = S_FIND;
            end
            S_FIND: begin
                n_win  = win_next;
                n_fill = fill_next;
                n_spos = s_next;
                if (hit) begin
                    fin        = 1'b1;
                    n_cur_byte = match_pos[POS_W-2:3];
                    n_cur_bit  = match_pos[2:0];
                end else if (s_next >= total) begin
                    fin        = 1'b1;
                    fin_status = bfr_pkg::ST_NOT_FOUND;
                end else if (r_spos[2:0] == 3'd7) begin
                    // advance to the prefetched byte, fetch the next one
                    n_bitbuf  = ram_rdata;
                    ram_re    = 1'b1;
                    ram_rbyte = s_next[POS_W-1:3] + BA_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_done   = 1'b1;
            n_state  = S_IDLE;
            n_result = '{bits_value:    fin_value,
                         status:        fin_status,
                         byte_position: n_cur_byte,
                         bit_position:  n_cur_bit};
        end
    end

    // ------------------------------------------------------------------
    // State and registered outputs
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cur_byte   <= '0;
            r_cur_bit    <= '0;
            r_dlen       <= '0;
            r_done       <= 1'b0;
            r_issue_left <= '0;
            r_recv_left  <= '0;
            r_rvalid     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cur_byte   <= n_cur_byte;
            r_cur_bit    <= n_cur_bit;
            r_dlen       <= n_dlen;
            r_done       <= n_done;
            r_issue_left <= n_issue_left;
            r_recv_left  <= n_recv_left;
            r_rvalid     <= n_rvalid;
        end
        r_item    <= n_item;
        r_result  <= n_result;
        r_rd_addr <= n_rd_addr;
        r_acc     <= n_acc;
        r_last    <= n_last;
        r_sh      <= n_sh;
        r_mask    <= n_mask;
        r_spos    <= n_spos;
        r_fill    <= n_fill;
        r_win     <= n_win;
        r_bitbuf  <= n_bitbuf;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == bfr_pkg::REG_DATA_LENGTH) ?
                      bfr_pkg::PDATA_W'(r_dlen) : '0;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_rvalid_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rvalid |-> (r_recv_left != '0))
        else $error("store read data returned with no byte outstanding");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIND) |-> (r_fill <= r_item.count_bits))
        else $error("search window filled past pattern width");

    a_cursor_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status != bfr_pkg::ST_OK)) |->
            ($stable(r_cur_byte) && $stable(r_cur_bit)))
        else $error("cursor moved on a failed command");

endmodule
